/* rtl/assert_macros.svh */
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same-cycle implication checked outside reset.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    `ASSERT_CLK(lbl, clk, rstn, (ante) |-> (cons), msg)

`endif

/* rtl/twre_pkg.sv */
`default_nettype none

package twre_pkg;

    localparam int ACC_W = 64;
    localparam int OUT_W = 25;
    localparam int REF_W = 16;
    localparam int CNT_W = 7;

    localparam logic [CNT_W-1:0] DIV_STEPS  = 7'd64;
    localparam logic [CNT_W-1:0] SQRT_STEPS = 7'd32;
    localparam logic [ACC_W-1:0] SQRT_BIT0  = 64'h4000_0000_0000_0000;
    localparam logic [OUT_W-1:0] OUT_MAX    = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_WMUL,
        ST_CHECK,
        ST_DIV,
        ST_SQRT,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_unit_req;

    typedef struct packed {
        logic done;
        logic busy;
    } t_unit_rsp;

    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [ACC_W-1:0] b);
        logic [ACC_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[ACC_W] ? '1 : s[ACC_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/twre_alu.sv */
`default_nettype none

// Shared multi-cycle unit: saturating shift-add multiply, restoring divide,
// bit-pair integer square root. One step per cycle.
module twre_alu (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire twre_pkg::t_unit_req          i_req,
    input  wire logic [twre_pkg::ACC_W-1:0]   i_op_a,
    input  wire logic [twre_pkg::ACC_W-1:0]   i_op_b,
    output twre_pkg::t_unit_rsp               o_rsp,
    output logic      [twre_pkg::ACC_W-1:0]   o_result
);

    localparam int W = twre_pkg::ACC_W;

    logic                        r_busy;
    logic                        r_done;
    twre_pkg::t_op               r_op;
    logic [twre_pkg::CNT_W-1:0]  r_cnt;
    logic [W-1:0]                r_x;    // mul: shifted multiplicand, div: dividend, sqrt: rest
    logic [W-1:0]                r_y;    // mul: multiplier, div: divisor, sqrt: trial bit
    logic [W-1:0]                r_acc;  // product, quotient or root
    logic [W-1:0]                r_rem;
    logic                        r_ovf;  // multiplicand shifted past the top
    logic                        r_sat;

    logic [W:0]   mul_sum;
    logic [W:0]   div_sh;
    logic         div_ge;
    logic [W:0]   div_diff;
    logic [W-1:0] sq_trial;
    logic         sq_ge;
    logic         step_end;

    always_comb begin
        mul_sum  = {1'b0, r_acc} + {1'b0, r_x};
        div_sh   = {r_rem, r_x[W-1]};
        div_ge   = (div_sh >= {1'b0, r_y});
        div_diff = div_sh - {1'b0, r_y};
        sq_trial = r_acc + r_y;
        sq_ge    = (r_x >= sq_trial);
        step_end = (r_op == twre_pkg::OP_MUL) ? (r_y == '0) : (r_cnt == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && step_end) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op  <= i_req.op;
            r_acc <= '0;
            r_rem <= '0;
            r_ovf <= 1'b0;
            r_sat <= 1'b0;
            r_x   <= i_op_a;
            unique case (i_req.op)
                twre_pkg::OP_MUL: begin
                    r_y   <= i_op_b;
                    r_cnt <= '0;
                end
                twre_pkg::OP_DIV: begin
                    r_y   <= i_op_b;
                    r_cnt <= twre_pkg::DIV_STEPS;
                end
                twre_pkg::OP_SQRT: begin
                    r_y   <= twre_pkg::SQRT_BIT0;
                    r_cnt <= twre_pkg::SQRT_STEPS;
                end
                default: begin
                    r_y   <= '0;
                    r_cnt <= '0;
                end
            endcase
        end else if (r_busy && !step_end) begin
            unique case (r_op)
                twre_pkg::OP_MUL: begin
                    if (r_y[0]) begin
                        r_acc <= mul_sum[W-1:0];
                        if (mul_sum[W] || r_ovf) begin
                            r_sat <= 1'b1;
                        end
                    end
                    r_ovf <= r_ovf | r_x[W-1];
                    r_x   <= {r_x[W-2:0], 1'b0};
                    r_y   <= {1'b0, r_y[W-1:1]};
                end
                twre_pkg::OP_DIV: begin
                    r_rem <= div_ge ? div_diff[W-1:0] : div_sh[W-1:0];
                    r_acc <= {r_acc[W-2:0], div_ge};
                    r_x   <= {r_x[W-2:0], 1'b0};
                    r_cnt <= r_cnt - 1'b1;
                end
                twre_pkg::OP_SQRT: begin
                    if (sq_ge) begin
                        r_x   <= r_x - sq_trial;
                        r_acc <= {1'b0, r_acc[W-1:1]} + r_y;
                    end else begin
                        r_acc <= {1'b0, r_acc[W-1:1]};
                    end
                    r_y   <= {2'b00, r_y[W-1:2]};
                    r_cnt <= r_cnt - 1'b1;
                end
                default: begin
                    r_cnt <= '0;
                end
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.busy = r_busy;
    assign o_result   = r_sat ? '1 : r_acc;

endmodule

`default_nettype wire

/* rtl/time_weighted_rms_tracking_error_unit.sv */
// Time-weighted RMS tracking error.
// Input channel (i_in_valid / o_in_stall): one sample per transfer with time,
// measured and setpoint position, setpoint flag and reference id/presence.
// Output channel (o_out_valid / i_out_stall): one RMS result per sample, in
// sample order. Results wait in an output register, so a new sample is taken
// while the previous result is still stalled.
// A sample that clears or only records its time goes straight to the done
// state; one that adds nothing checks the total and, while it is zero, also
// goes straight to done. Otherwise a 64-step divide and a 32-step root run
// through one shared unit. An accumulating sample first runs three squares
// and one dt multiply on that unit.
// Input flow: the next sample is taken at the earliest in the cycle after the
// result is loaded; o_in_stall is high while the sequencer works, and stays high
// if the output register is still full and stalled when the next result is ready.
// Reset (synchronous, active low) forgets the reference and the time and
// clears both accumulators; no result is pending afterwards.
`default_nettype none
`include "assert_macros.svh"

module time_weighted_rms_tracking_error_unit #(
    parameter int POS_WIDTH  = 24,
    parameter int TIME_WIDTH = 40
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // sample channel
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic        [TIME_WIDTH-1:0]      i_time_us,
    input  wire logic signed [POS_WIDTH-1:0]       i_pos_x,
    input  wire logic signed [POS_WIDTH-1:0]       i_pos_y,
    input  wire logic signed [POS_WIDTH-1:0]       i_pos_z,
    input  wire logic signed [POS_WIDTH-1:0]       i_target_x,
    input  wire logic signed [POS_WIDTH-1:0]       i_target_y,
    input  wire logic signed [POS_WIDTH-1:0]       i_target_z,
    input  wire logic                              i_target_valid,
    input  wire logic                              i_ref_present,
    input  wire logic        [twre_pkg::REF_W-1:0] i_ref_id,
    // result channel
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic             [twre_pkg::OUT_W-1:0] o_rms_error_mm
);

    localparam int W = twre_pkg::ACC_W;

    // |p - t| always fits POS_WIDTH bits: the difference stays within
    // +/-(2^POS_WIDTH - 1).
    function automatic logic [POS_WIDTH-1:0] abs_diff(input logic signed [POS_WIDTH-1:0] p,
                                                      input logic signed [POS_WIDTH-1:0] t);
        logic signed [POS_WIDTH:0] d;
        logic        [POS_WIDTH:0] m;
        d = (POS_WIDTH+1)'(p) - (POS_WIDTH+1)'(t);
        m = d[POS_WIDTH] ? unsigned'(-d) : unsigned'(d);
        return m[POS_WIDTH-1:0];
    endfunction

    twre_pkg::t_state r_state, n_state;
    logic             r_issued;

    // tracking state
    logic                        r_ref_valid;
    logic [twre_pkg::REF_W-1:0]  r_last_ref;
    logic                        r_time_valid;
    logic [TIME_WIDTH-1:0]       r_last_time;
    logic [W-1:0]                r_sum;
    logic [TIME_WIDTH-1:0]       r_total;

    // per-sample working registers
    logic [TIME_WIDTH-1:0]       r_dt;
    logic [POS_WIDTH-1:0]        r_mag [3];
    logic [1:0]                  r_axis;
    logic [W-1:0]                r_sq;
    logic [W-1:0]                r_quot;
    logic [twre_pkg::OUT_W-1:0]  r_res;

    // output register
    logic                        r_out_valid;
    logic [twre_pkg::OUT_W-1:0]  r_out_data;

    // shared unit
    twre_pkg::t_unit_req unit_req;
    twre_pkg::t_unit_rsp unit_rsp;
    logic [W-1:0]        unit_a;
    logic [W-1:0]        unit_b;
    logic [W-1:0]        unit_res;

    logic                 in_xfer;
    logic                 no_ref;
    logic                 new_ref;
    logic                 new_time;
    logic                 accum;
    logic                 out_load;
    logic [TIME_WIDTH:0]  total_sum;

    assign o_in_stall = (r_state != twre_pkg::ST_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;

    // Sample classification, in priority order.
    assign no_ref   = !i_ref_present;
    assign new_ref  = !r_ref_valid || (i_ref_id != r_last_ref);
    assign new_time = !r_time_valid;
    assign accum    = i_target_valid && (i_time_us > r_last_time);

    assign out_load  = (r_state == twre_pkg::ST_DONE) && (!r_out_valid || !i_out_stall);
    assign total_sum = {1'b0, r_total} + {1'b0, r_dt};

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            twre_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    priority if (no_ref || new_ref || new_time) begin
                        n_state = twre_pkg::ST_DONE;
                    end else if (accum) begin
                        n_state = twre_pkg::ST_SQ;
                    end else begin
                        n_state = twre_pkg::ST_CHECK;
                    end
                end
            end
            twre_pkg::ST_SQ: begin
                if (unit_rsp.done && (r_axis == 2'd2)) begin
                    n_state = twre_pkg::ST_WMUL;
                end
            end
            twre_pkg::ST_WMUL: begin
                if (unit_rsp.done) begin
                    n_state = twre_pkg::ST_CHECK;
                end
            end
            twre_pkg::ST_CHECK: begin
                n_state = (r_total != '0) ? twre_pkg::ST_DIV : twre_pkg::ST_DONE;
            end
            twre_pkg::ST_DIV: begin
                if (unit_rsp.done) begin
                    n_state = twre_pkg::ST_SQRT;
                end
            end
            twre_pkg::ST_SQRT: begin
                if (unit_rsp.done) begin
                    n_state = twre_pkg::ST_DONE;
                end
            end
            twre_pkg::ST_DONE: begin
                if (out_load) begin
                    n_state = twre_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = twre_pkg::ST_IDLE;
            end
        endcase
    end

    // Unit commands: one start per operation, operands picked by state.
    always_comb begin
        unit_req.start = 1'b0;
        unit_req.op    = twre_pkg::OP_MUL;
        unit_a         = '0;
        unit_b         = '0;
        unique case (r_state)
            twre_pkg::ST_SQ: begin
                unit_req.start = !r_issued;
                unit_req.op    = twre_pkg::OP_MUL;
                unit_a         = {{(W-POS_WIDTH){1'b0}}, r_mag[r_axis]};
                unit_b         = {{(W-POS_WIDTH){1'b0}}, r_mag[r_axis]};
            end
            twre_pkg::ST_WMUL: begin
                unit_req.start = !r_issued;
                unit_req.op    = twre_pkg::OP_MUL;
                unit_a         = r_sq;
                unit_b         = {{(W-TIME_WIDTH){1'b0}}, r_dt};
            end
            twre_pkg::ST_DIV: begin
                unit_req.start = !r_issued;
                unit_req.op    = twre_pkg::OP_DIV;
                unit_a         = r_sum;
                unit_b         = {{(W-TIME_WIDTH){1'b0}}, r_total};
            end
            twre_pkg::ST_SQRT: begin
                unit_req.start = !r_issued;
                unit_req.op    = twre_pkg::OP_SQRT;
                unit_a         = r_quot;
            end
            default: begin
                unit_req.start = 1'b0;
            end
        endcase
    end

    twre_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (unit_req),
        .i_op_a   (unit_a),
        .i_op_b   (unit_b),
        .o_rsp    (unit_rsp),
        .o_result (unit_res)
    );

    // Control and tracking state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= twre_pkg::ST_IDLE;
            r_issued     <= 1'b0;
            r_ref_valid  <= 1'b0;
            r_last_ref   <= '0;
            r_time_valid <= 1'b0;
            r_sum        <= '0;
            r_total      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (unit_req.start) begin
                r_issued <= 1'b1;
            end else if (unit_rsp.done) begin
                r_issued <= 1'b0;
            end

            if (in_xfer) begin
                priority if (no_ref) begin
                    r_ref_valid  <= 1'b0;
                    r_time_valid <= 1'b0;
                    r_sum        <= '0;
                    r_total      <= '0;
                end else if (new_ref) begin
                    r_ref_valid  <= 1'b1;
                    r_last_ref   <= i_ref_id;
                    r_time_valid <= 1'b0;
                    r_sum        <= '0;
                    r_total      <= '0;
                end else if (new_time) begin
                    r_time_valid <= 1'b1;
                    r_sum        <= '0;
                    r_total      <= '0;
                end
            end

            // total saturates at all ones
            if ((r_state == twre_pkg::ST_WMUL) && unit_rsp.done) begin
                r_sum   <= twre_pkg::sat_add(r_sum, unit_res);
                r_total <= total_sum[TIME_WIDTH] ? '1 : total_sum[TIME_WIDTH-1:0];
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            // time is taken when none is recorded for the held reference, or with a setpoint
            if (i_ref_present && !new_ref && (new_time || i_target_valid)) begin
                r_last_time <= i_time_us;
            end
            r_dt     <= i_time_us - r_last_time;
            r_mag[0] <= abs_diff(i_pos_x, i_target_x);
            r_mag[1] <= abs_diff(i_pos_y, i_target_y);
            r_mag[2] <= abs_diff(i_pos_z, i_target_z);
            r_axis   <= '0;
            r_sq     <= '0;
            r_res    <= '0;
        end
        if ((r_state == twre_pkg::ST_SQ) && unit_rsp.done) begin
            r_sq   <= twre_pkg::sat_add(r_sq, unit_res);
            r_axis <= r_axis + 2'd1;
        end
        if ((r_state == twre_pkg::ST_DIV) && unit_rsp.done) begin
            r_quot <= unit_res;
        end
        if ((r_state == twre_pkg::ST_SQRT) && unit_rsp.done) begin
            r_res <= (unit_res[W-1:twre_pkg::OUT_W] != '0) ? twre_pkg::OUT_MAX
                                                          : unit_res[twre_pkg::OUT_W-1:0];
        end
        if (out_load) begin
            r_out_data <= r_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_rms_error_mm = r_out_data;

    `ASSERT_IMPL(a_idle_no_cmd, i_clk, i_rst_n, r_state == twre_pkg::ST_IDLE, !r_issued && !unit_rsp.busy, "unit command outstanding while idle")
    `ASSERT_IMPL(a_done_in_op, i_clk, i_rst_n, unit_rsp.done, (r_state == twre_pkg::ST_SQ) || (r_state == twre_pkg::ST_WMUL) || (r_state == twre_pkg::ST_DIV) || (r_state == twre_pkg::ST_SQRT), "unit finished outside an operation state")
    `ASSERT_IMPL(a_zero_total_sum, i_clk, i_rst_n, r_total == '0, r_sum == '0, "weighted sum nonzero with zero total time")
    `ASSERT_CLK(a_out_from_done, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state == twre_pkg::ST_DONE), "result loaded outside the done state")

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam int PW = 24;
    localparam int TW = 40;
    localparam int REF_W = twre_pkg::REF_W;
    localparam int OUT_W = twre_pkg::OUT_W;
    localparam logic [OUT_W-1:0] OUT_MAX = twre_pkg::OUT_MAX;

    // run shaping
    localparam int RANDOM_SAMPLES = 1200;
    localparam int IDLE_PCT       = 21;
    localparam int CALM_FROM      = 400;    // no idling on either side in this window
    localparam int CALM_TO        = 550;
    localparam int LATE_HOLD      = 700;    // second drain point, first is after directed part
    localparam int QUIET_LIMIT    = 20000;  // cycles without any transfer before giving up
    localparam int TAIL_CYCLES    = 300;    // longer than the worst-case sample latency
    localparam int PRINT_CAP      = 100;

    localparam int PMAX = 8388607;
    localparam int PMIN = -8388608;
    localparam logic [TW-1:0] TMAX = '1;

    typedef struct packed {
        logic [TW-1:0]    time_us;
        logic [PW-1:0]    pos_x;
        logic [PW-1:0]    pos_y;
        logic [PW-1:0]    pos_z;
        logic [PW-1:0]    tgt_x;
        logic [PW-1:0]    tgt_y;
        logic [PW-1:0]    tgt_z;
        logic             tgt_ok;
        logic             ref_on;
        logic [REF_W-1:0] ref_id;
    } t_sample;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // sample channel
    logic    in_valid = 1'b0;
    t_sample drv      = '0;
    logic    o_in_stall;

    // result channel
    logic             out_stall = 1'b0;
    logic             o_out_valid;
    logic [OUT_W-1:0] o_rms_error_mm;

    t_sample          pending_q[$];      // samples still to be sent
    logic [OUT_W-1:0] rms_expected_q[$]; // predicted RMS values, oldest first

    int samples_sent   = 0;
    int directed_count = 0;
    int error_count    = 0;
    int quiet_cycles   = 0;

    // predictor state: reference tracking, time tracking, accumulators
    logic [REF_W-1:0] trk_ref     = '0;
    logic             trk_ref_ok  = 1'b0;
    logic [TW-1:0]    trk_time    = '0;
    logic             trk_time_ok = 1'b0;
    logic [63:0]      err_sum     = '0;
    logic [TW-1:0]    time_sum    = '0;

    // generator state for the random part
    logic [TW-1:0]    gen_time;
    logic [REF_W-1:0] gen_ref;

    time_weighted_rms_tracking_error_unit #(
        .POS_WIDTH  (PW),
        .TIME_WIDTH (TW)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (o_in_stall),
        .i_time_us      (drv.time_us),
        .i_pos_x        (drv.pos_x),
        .i_pos_y        (drv.pos_y),
        .i_pos_z        (drv.pos_z),
        .i_target_x     (drv.tgt_x),
        .i_target_y     (drv.tgt_y),
        .i_target_z     (drv.tgt_z),
        .i_target_valid (drv.tgt_ok),
        .i_ref_present  (drv.ref_on),
        .i_ref_id       (drv.ref_id),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_rms_error_mm (o_rms_error_mm)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        // everything is counted, printing stops after a while on a broken block
        if (error_count < PRINT_CAP) begin
            $display("%0t mismatch: %s", $realtime, msg);
        end
        error_count++;
    endtask

    task automatic add_pending(input t_sample s);
        pending_q.insert(pending_q.size(), s);
    endtask

    function automatic logic [63:0] axis_err_sq(input logic [PW-1:0] p, input logic [PW-1:0] t);
        longint d;
        d = longint'($signed(p)) - longint'($signed(t));
        return 64'(d * d);  // |d| < 2^24, so no saturation needed at this width
    endfunction

    function automatic logic [63:0] sum_sat(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    // Integer square root, bit by bit from the top: keep a bit if its square still fits.
    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] cand;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if (cand * cand <= v) begin
                root = cand;
            end
        end
        return root;
    endfunction

    // Advance the tracker by one sample and return the RMS value it must report.
    function automatic logic [OUT_W-1:0] track_sample(input t_sample s);
        logic [TW-1:0]  prev;
        logic [TW-1:0]  dt;
        logic [63:0]    sq;
        logic [127:0]   prod;
        logic [TW:0]    tsum;
        logic [63:0]    root;

        // no reference queued: forget everything
        if (!s.ref_on) begin
            trk_ref_ok  = 1'b0;
            trk_time_ok = 1'b0;
            err_sum     = '0;
            time_sum    = '0;
            return '0;
        end
        // first reference or a different one: restart on it
        if (!trk_ref_ok || s.ref_id != trk_ref) begin
            trk_ref     = s.ref_id;
            trk_ref_ok  = 1'b1;
            trk_time_ok = 1'b0;
            err_sum     = '0;
            time_sum    = '0;
            return '0;
        end
        // first sample of a reference only records its time
        if (!trk_time_ok) begin
            trk_time    = s.time_us;
            trk_time_ok = 1'b1;
            err_sum     = '0;
            time_sum    = '0;
            return '0;
        end

        if (s.tgt_ok) begin
            prev     = trk_time;
            trk_time = s.time_us;
            // only a strictly later time accumulates, no wrap handling
            if (s.time_us > prev) begin
                dt   = s.time_us - prev;
                sq   = axis_err_sq(s.pos_x, s.tgt_x);
                sq   = sum_sat(sq, axis_err_sq(s.pos_y, s.tgt_y));
                sq   = sum_sat(sq, axis_err_sq(s.pos_z, s.tgt_z));
                prod = 128'(dt) * 128'(sq);
                err_sum = sum_sat(err_sum, (prod[127:64] != '0) ? '1 : prod[63:0]);
                tsum = {1'b0, time_sum} + {1'b0, dt};
                time_sum = tsum[TW] ? '1 : tsum[TW-1:0];
            end
        end

        if (time_sum == '0) begin
            return '0;
        end
        root = floor_sqrt(err_sum / 64'(time_sum));
        return (root > 64'(OUT_MAX)) ? OUT_MAX : root[OUT_W-1:0];
    endfunction

    function automatic bit in_calm_stretch();
        return samples_sent >= CALM_FROM && samples_sent < CALM_TO;
    endfunction

    function automatic bit idle_now();
        return !in_calm_stretch() && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    // sender holds off at these points until every result is back
    function automatic bit at_drain_point(input int n);
        return n == directed_count || n == LATE_HOLD;
    endfunction

    function automatic t_sample mk(input logic [TW-1:0] t,
                                   input int px, input int py, input int pz,
                                   input int tx, input int ty, input int tz,
                                   input logic tv, input logic rp,
                                   input logic [REF_W-1:0] id);
        t_sample s;
        s.time_us = t;
        s.pos_x   = PW'(px);
        s.pos_y   = PW'(py);
        s.pos_z   = PW'(pz);
        s.tgt_x   = PW'(tx);
        s.tgt_y   = PW'(ty);
        s.tgt_z   = PW'(tz);
        s.tgt_ok  = tv;
        s.ref_on  = rp;
        s.ref_id  = id;
        return s;
    endfunction

    function automatic logic [PW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return PW'($urandom);
            1: return $urandom_range(0, 1) ? PW'(PMAX) : PW'(PMIN);
            default: return PW'($urandom_range(0, 4000)) - PW'(2000);
        endcase
    endfunction

    // setpoint mostly close to the measured position, sometimes anywhere
    function automatic logic [PW-1:0] rand_target(input logic [PW-1:0] p);
        if ($urandom_range(0, 3) == 0) begin
            return rand_coord();
        end
        return p + PW'($urandom_range(0, 200)) - PW'(100);
    endfunction

    function automatic logic [TW-1:0] rand_time();
        return TW'({$urandom, $urandom});
    endfunction

    function automatic t_sample rand_sample();
        t_sample s;
        s.time_us = rand_time();
        s.pos_x   = rand_coord();
        s.pos_y   = rand_coord();
        s.pos_z   = rand_coord();
        s.tgt_x   = rand_target(s.pos_x);
        s.tgt_y   = rand_target(s.pos_y);
        s.tgt_z   = rand_target(s.pos_z);
        s.tgt_ok  = $urandom_range(0, 9) != 0;
        s.ref_on  = 1'b1;
        s.ref_id  = REF_W'($urandom);
        return s;
    endfunction

    // One tracking run on a single reference: mostly small time steps with random
    // content, a few large jumps, backward or repeated timestamps and missing setpoints.
    task automatic add_tracking_run();
        t_sample s;
        int      len;
        if ($urandom_range(0, 3) != 0) begin
            gen_ref = REF_W'($urandom);
        end
        gen_time = ($urandom_range(0, 3) == 0) ? rand_time() : TW'($urandom_range(0, 100000));
        len = $urandom_range(3, 40);
        for (int k = 0; k < len; k++) begin
            s = rand_sample();
            s.ref_id = gen_ref;
            case ($urandom_range(0, 19))
                0: gen_time = gen_time - TW'($urandom_range(0, 500));  // backward or same
                1: gen_time = gen_time + rand_time();                  // huge jump, may wrap
                2, 3: gen_time = gen_time + TW'($urandom_range(1, 1000000));
                default: gen_time = gen_time + TW'($urandom_range(1, 2000));
            endcase
            s.time_us = gen_time;
            add_pending(s);
        end
    endtask

    // Driver: holds the payload while stalled, idles at random, and pauses at
    // the drain points until the result side has caught up.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                rms_expected_q.insert(rms_expected_q.size(), track_sample(drv));
                samples_sent++;
            end
            if (!in_valid || !o_in_stall) begin
                if (pending_q.size() == 0 || idle_now() ||
                        (at_drain_point(samples_sent) && rms_expected_q.size() != 0)) begin
                    in_valid <= 1'b0;
                end else begin
                    drv      <= pending_q.pop_front();
                    in_valid <= 1'b1;
                end
            end
        end
    end

    // Monitor: checks each result transfer against the oldest prediction and
    // stalls the result channel at random.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !out_stall) begin
                if (rms_expected_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d with none expected", o_rms_error_mm));
                end else if (o_rms_error_mm !== rms_expected_q[0]) begin
                    report_mismatch($sformatf("rms_error_mm got %0d expected %0d",
                                              o_rms_error_mm, rms_expected_q[0]));
                    void'(rms_expected_q.pop_front());
                end else begin
                    void'(rms_expected_q.pop_front());
                end
            end
            out_stall <= idle_now();
        end
    end

    // Watchdog: too long without any transfer on either channel ends the run.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb NOT OK");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        // directed: every special case, field extremes
        add_pending(mk(0, 1, 2, 3, 0, 0, 0, 1, 0, 16'h0000));          // no reference
        add_pending(mk(10, 1, 2, 3, 0, 0, 0, 1, 1, 16'hFFFF));         // new reference
        add_pending(mk(100, 1, 2, 3, 0, 0, 0, 1, 1, 16'hFFFF));        // time recorded
        add_pending(mk(200, PMAX, PMAX, PMAX, PMIN, PMIN, PMIN, 1, 1, 16'hFFFF));
        add_pending(mk(300, 5, 6, 7, 0, 0, 0, 0, 1, 16'hFFFF));        // no setpoint
        add_pending(mk(150, 3, -4, 12, 0, 0, 0, 1, 1, 16'hFFFF));      // time backward
        add_pending(mk(150, 3, -4, 12, 0, 0, 0, 1, 1, 16'hFFFF));      // time repeated
        add_pending(mk(160, 3, -4, 12, 0, 0, 0, 1, 1, 16'hFFFF));
        add_pending(mk(170, PMIN, PMIN, PMIN, PMAX, PMAX, PMAX, 1, 1, 16'hFFFF));
        add_pending(mk(0, 0, 0, 0, 0, 0, 0, 1, 1, 16'h0000));          // id change
        add_pending(mk(0, 0, 0, 0, 0, 0, 0, 1, 1, 16'h0000));          // time 0
        // full-range dt with max error: product saturates
        add_pending(mk(TMAX, PMAX, PMAX, PMAX, PMIN, PMIN, PMIN, 1, 1, 16'h0000));
        add_pending(mk(0, 0, 0, 0, 0, 0, 0, 1, 1, 16'h0000));
        // again: error sum and total time both saturate
        add_pending(mk(TMAX, PMIN, PMIN, PMIN, PMAX, PMAX, PMAX, 1, 1, 16'h0000));
        add_pending(mk(TMAX, 0, 0, 0, 0, 0, 0, 0, 1, 16'h0000));
        add_pending(mk(5, 0, 0, 0, 0, 0, 0, 1, 0, 16'h0000));          // reference gone
        add_pending(mk(5, 0, 0, 0, 0, 0, 0, 1, 1, 16'h0000));          // same id, restart
        add_pending(mk(6, 0, 0, 0, 0, 0, 0, 1, 1, 16'h0000));
        add_pending(mk(7, 100, -100, 50, 100, -100, 50, 1, 1, 16'h0000)); // zero error
        add_pending(mk(8, -1, -1, -1, 0, 0, 0, 1, 1, 16'h0000));
        add_pending(mk(9, 0, 0, 0, -1, -1, -1, 1, 1, 16'h5A5A));
        add_pending(mk(40'h55_5555_5555, 0, 0, 0, 0, 0, 0, 1, 1, 16'h5A5A));
        add_pending(mk(40'hAA_AAAA_AAAA, 1000, -2000, 3000, -1000, 2000, -3000,
                       1, 1, 16'h5A5A));
        directed_count = pending_q.size();

        // random: mostly tracking runs, some loose samples as noise
        gen_ref = '0;
        while (pending_q.size() < directed_count + RANDOM_SAMPLES) begin
            if ($urandom_range(0, 9) == 0) begin
                add_pending(rand_sample());
                pending_q[$].ref_on = $urandom_range(0, 2) != 0;
            end else begin
                add_tracking_run();
            end
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_q.size() != 0 || in_valid || rms_expected_q.size() != 0) begin
            @(posedge clk);
        end
        // anything arriving now is an extra result and gets flagged by the monitor
        repeat (TAIL_CYCLES) @(posedge clk);
        if (rms_expected_q.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", rms_expected_q.size()));
        end

        if (error_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

/* time_weighted_rms_tracking_error_unit.f */
+incdir+rtl
rtl/twre_pkg.sv
rtl/twre_alu.sv
rtl/time_weighted_rms_tracking_error_unit.sv
tb/tb.sv
